/* sv/rgb_box_blur_3x3_core_defines.svh */
// ----------------------------------------------------------------------------
// rgb_box_blur_3x3_core_defines.svh
// Assertion macros used by the checker file of the blur core.
// ----------------------------------------------------------------------------
`ifndef RGB_BOX_BLUR_3X3_CORE_DEFINES_SVH
`define RGB_BOX_BLUR_3X3_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define RBB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rbb assertion failed");

// next-cycle implication, off during reset
`define RBB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rbb assertion failed");

// next-cycle implication, also checked across reset
`define RBB_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rbb reset assertion failed");

`endif

/* sv/rbb_pkg.sv */
// ----------------------------------------------------------------------------
// rbb_pkg
// Types and constants of the 3x3 RGB box blur core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rbb_pkg;

  localparam int FW_W       = 11;  // frame_width register
  localparam int FH_W       = 16;  // frame_height register
  localparam int ROW_W      = 17;  // input row runs to height + 1 while draining
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int CSUM_W     = 10;  // three 8-bit values
  localparam int SUM_W      = 12;  // nine 8-bit values
  localparam int RECIP_W    = 13;

  localparam logic [FW_W-1:0] FW_RESET = 11'd640;
  localparam logic [FH_W-1:0] FH_RESET = 16'd480;

  // reciprocals: floor(x/3) = (x*2731)>>13, floor(x/9) = (x*7282)>>16 for x < 2300
  localparam logic [RECIP_W-1:0] RECIP_ONE = 13'd1;
  localparam logic [RECIP_W-1:0] RECIP3    = 13'd2731;
  localparam logic [RECIP_W-1:0] RECIP9    = 13'd7282;
  localparam int                 RECIP3_SH = 13;
  localparam int                 RECIP9_SH = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } rbb_reg_idx_t;

  // [2] red, [1] green, [0] blue
  typedef logic [2:0][7:0]        rbb_px_t;
  typedef logic [2:0][CSUM_W-1:0] rbb_csum_t;

  typedef struct packed {
    rbb_px_t upper;
    rbb_px_t mid;
    rbb_px_t lower;
  } rbb_col_t;

  // neighbors inside the frame for one output pixel
  typedef struct packed {
    logic above;
    logic below;
    logic left;
    logic right;
  } rbb_mask_t;

endpackage

/* sv/rbb_line_store.sv */
// ----------------------------------------------------------------------------
// rbb_line_store
// One-row pixel store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbb_line_store #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

/* sv/rbb_window_cell.sv */
// ----------------------------------------------------------------------------
// rbb_window_cell
// One column of the 3x3 window: holds three pixels, passes them left on shift
// and sums them per channel over the rows inside the frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbb_window_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              shift,
  input  rbb_pkg::rbb_col_t  col_in,
  input  rbb_pkg::rbb_mask_t mask,
  output rbb_pkg::rbb_col_t  col_out,
  output rbb_pkg::rbb_csum_t csum
);

  import rbb_pkg::*;

  rbb_col_t col;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
    end else if (shift) begin
      col <= col_in;
    end
  end

  assign col_out = col;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      csum[c] = CSUM_W'(col.mid[c])
              + (mask.above ? CSUM_W'(col.upper[c]) : CSUM_W'(0))
              + (mask.below ? CSUM_W'(col.lower[c]) : CSUM_W'(0));
    end
  end

endmodule

/* sv/rgb_box_blur_3x3_core.sv */
// ----------------------------------------------------------------------------
// rgb_box_blur_3x3_core
// Throughput: one item per cycle, sustained, while results are taken.
// Pipeline: from item accept to result valid with a free output, an item
//   passes the stages line-store read register, window shift, sum register,
//   output register. A result shows up width+1 items after its pixel.
// Reset (rst, synchronous): clears counters, valids and the window, sets
//   frame_width 640 and frame_height 480; line stores are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_box_blur_3x3_core #(
  parameter int MAX_ROW_PIXELS = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  // input pixel channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_red,
  input  logic [7:0]                     in_green,
  input  logic [7:0]                     in_blue,
  input  logic                           drain,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_red,
  output logic [7:0]                     out_green,
  output logic [7:0]                     out_blue,
  output logic                           frame_last,
  // configuration write port
  input  logic                           cfg_wr_en,
  input  logic [rbb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbb_pkg::CFG_DATA_W-1:0] cfg_data
);

  import rbb_pkg::*;

  localparam int XW  = $clog2(MAX_ROW_PIXELS);      // column / store address
  localparam int WW  = $clog2(MAX_ROW_PIXELS + 1);  // holds the width itself
  localparam int EWW = (WW > FW_W) ? WW : FW_W;

  // --------------------------------------------------------------------------
  // Configuration and effective frame size
  // --------------------------------------------------------------------------
  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;
  logic [EWW-1:0]  eff_w;
  logic [FH_W-1:0] eff_h;

  // zero width acts as one, too wide clamps to the store depth
  always_comb begin
    if (frame_width == '0) begin
      eff_w = EWW'(1);
    end else if (EWW'(frame_width) > EWW'(MAX_ROW_PIXELS)) begin
      eff_w = EWW'(MAX_ROW_PIXELS);
    end else begin
      eff_w = EWW'(frame_width);
    end
    eff_h = (frame_height == '0) ? FH_W'(1) : frame_height;
  end

  // --------------------------------------------------------------------------
  // Raster counters
  // --------------------------------------------------------------------------
  logic [XW-1:0]    in_col, in_col_next;
  logic [ROW_W-1:0] in_row, in_row_next;
  logic [XW-1:0]    out_col, out_col_next;
  logic [FH_W-1:0]  out_row, out_row_next;

  logic      row_in_frame;
  logic      eff_item;    // item takes part (pixel in frame or drain after it)
  logic      emit;        // item completes a window
  logic      take;
  rbb_mask_t cur_mask;
  logic      cur_last;
  rbb_px_t   new_px;

  // pipeline handshake
  logic o_free, c_move, c_free, b_move, b_free, a_move;

  always_comb begin
    row_in_frame   = in_row < ROW_W'(eff_h);
    eff_item       = drain ? !row_in_frame : row_in_frame;
    emit           = (in_row >= ROW_W'(2)) || ((in_row == ROW_W'(1)) && (in_col != '0));
    cur_mask.above = out_row != '0;
    cur_mask.below = (ROW_W'(out_row) + ROW_W'(1)) < ROW_W'(eff_h);
    cur_mask.left  = out_col != '0;
    cur_mask.right = (EWW'(out_col) + EWW'(1)) < eff_w;
    cur_last       = !cur_mask.below && !cur_mask.right;
    new_px         = drain ? '0 : {in_red, in_green, in_blue};
    take           = in_valid && in_ready && eff_item;
  end

  always_comb begin
    if ((EWW'(in_col) + EWW'(1)) >= eff_w) begin
      in_col_next = '0;
      in_row_next = in_row + ROW_W'(1);
    end else begin
      in_col_next = in_col + XW'(1);
      in_row_next = in_row;
    end
    out_col_next = out_col;
    out_row_next = out_row;
    if (emit) begin
      if (cur_last) begin
        // frame done: everything restarts for the next frame
        in_col_next  = '0;
        in_row_next  = '0;
        out_col_next = '0;
        out_row_next = '0;
      end else if (!cur_mask.right) begin
        out_col_next = '0;
        out_row_next = out_row + FH_W'(1);
      end else begin
        out_col_next = out_col + XW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_RESET;
      frame_height <= FH_RESET;
      in_col       <= '0;
      in_row       <= '0;
      out_col      <= '0;
      out_row      <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        default: ;
      endcase
      // any write restarts the frame
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (take) begin
      in_col  <= in_col_next;
      in_row  <= in_row_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: a stage moves when the next one is empty or moving,
  // so bubbles collapse and input keeps flowing behind a waiting result.
  // --------------------------------------------------------------------------
  logic a_v, b_v, c_v;

  always_comb begin
    o_free   = !out_valid || out_ready;
    c_move   = c_v && o_free;
    c_free   = !c_v || o_free;
    b_move   = b_v && c_free;
    b_free   = !b_v || c_free;
    a_move   = a_v && b_free;
    in_ready = !a_v || b_free;
  end

  // --------------------------------------------------------------------------
  // Stage A: line-store read. The newer row moves into the older store when
  // the item leaves stage A, so its read of the same column is forwarded.
  // --------------------------------------------------------------------------
  rbb_px_t       older_rd, newer_rd;
  logic [XW-1:0] a_x;
  rbb_px_t       a_pix;
  logic          a_emit, a_last, a_fwd;
  rbb_px_t       a_fwd_px;
  rbb_mask_t     a_mask;
  rbb_px_t       a_upper;
  rbb_col_t      new_col;

  rbb_line_store #(
    .DEPTH (MAX_ROW_PIXELS),
    .WIDTH ($bits(rbb_px_t))
  ) u_older_store (
    .clk     (clk),
    .rd_en   (take),
    .rd_addr (in_col),
    .rd_data (older_rd),
    .wr_en   (a_move),
    .wr_addr (a_x),
    .wr_data (newer_rd)
  );

  rbb_line_store #(
    .DEPTH (MAX_ROW_PIXELS),
    .WIDTH ($bits(rbb_px_t))
  ) u_newer_store (
    .clk     (clk),
    .rd_en   (take),
    .rd_addr (in_col),
    .rd_data (newer_rd),
    .wr_en   (take),
    .wr_addr (in_col),
    .wr_data (new_px)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (take) begin
      a_v <= 1'b1;
    end else if (a_move) begin
      a_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_x      <= in_col;
      a_pix    <= new_px;
      a_emit   <= emit;
      a_last   <= cur_last;
      a_mask   <= cur_mask;
      a_fwd    <= a_move && (a_x == in_col);  // one-column frames
      a_fwd_px <= newer_rd;
    end
  end

  assign a_upper = a_fwd ? a_fwd_px : older_rd;

  always_comb begin
    new_col.upper = a_upper;
    new_col.mid   = newer_rd;
    new_col.lower = a_pix;
  end

  // --------------------------------------------------------------------------
  // Stage B: window as a chain of three column cells, newest on the right.
  // After the shift the output pixel always sits in the middle cell.
  // --------------------------------------------------------------------------
  rbb_mask_t b_mask;
  logic      b_last;
  rbb_col_t  cell_in  [3];
  rbb_col_t  cell_out [3];
  rbb_csum_t cell_sum [3];

  for (genvar j = 0; j < 3; j++) begin : g_cell
    if (j == 2) begin : g_head
      assign cell_in[j] = new_col;
    end else begin : g_link
      assign cell_in[j] = cell_out[j+1];
    end
    rbb_window_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .shift   (a_move),
      .col_in  (cell_in[j]),
      .mask    (b_mask),
      .col_out (cell_out[j]),
      .csum    (cell_sum[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (a_move) begin
      b_v <= a_emit;  // items that only fill the window stop here
    end else if (b_move) begin
      b_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      b_mask <= a_mask;
      b_last <= a_last;
    end
  end

  // column sums with the left and right columns masked
  logic [2:0][SUM_W-1:0] b_sum;
  logic [1:0]            b_rows, b_cols;
  logic [3:0]            b_n;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      b_sum[c] = SUM_W'(cell_sum[1][c])
               + (b_mask.left  ? SUM_W'(cell_sum[0][c]) : SUM_W'(0))
               + (b_mask.right ? SUM_W'(cell_sum[2][c]) : SUM_W'(0));
    end
    b_rows = 2'd1 + 2'(b_mask.above) + 2'(b_mask.below);
    b_cols = 2'd1 + 2'(b_mask.left) + 2'(b_mask.right);
    b_n    = 4'(b_rows) * 4'(b_cols);
  end

  // --------------------------------------------------------------------------
  // Stage C: sums registered; rounded average formed into the output register
  // --------------------------------------------------------------------------
  logic [2:0][SUM_W-1:0] c_sum;
  logic [3:0]            c_n;
  logic                  c_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (b_move) begin
      c_v <= 1'b1;
    end else if (c_move) begin
      c_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_move) begin
      c_sum  <= b_sum;
      c_n    <= b_n;
      c_last <= b_last;
    end
  end

  // floor((2s + n) / 2n): a shift takes out the powers of two, a reciprocal
  // multiply takes out the remaining 3 or 9
  function automatic logic [7:0] round_avg(logic [SUM_W-1:0] s, logic [3:0] n);
    logic [SUM_W:0]           v;
    logic [SUM_W-1:0]         t;
    logic [RECIP_W-1:0]       m;
    int                       k;
    logic [SUM_W+RECIP_W-1:0] p;
    v = {s, 1'b0} + (SUM_W+1)'(n);
    t = SUM_W'(v >> 1);
    m = RECIP_ONE;
    k = 0;
    case (n)
      4'd2: begin
        t = SUM_W'(v >> 2);
      end
      4'd4: begin
        t = SUM_W'(v >> 3);
      end
      4'd3: begin
        m = RECIP3;
        k = RECIP3_SH;
      end
      4'd6: begin
        t = SUM_W'(v >> 2);
        m = RECIP3;
        k = RECIP3_SH;
      end
      4'd9: begin
        m = RECIP9;
        k = RECIP9_SH;
      end
      default: ;
    endcase
    p = (SUM_W+RECIP_W)'(t) * (SUM_W+RECIP_W)'(m);
    return 8'(p >> k);
  endfunction

  logic [2:0][7:0] q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (c_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (c_move) begin
      for (int c = 0; c < 3; c++) begin
        q[c] <= round_avg(c_sum[c], c_n);
      end
      frame_last <= c_last;
    end
  end

  assign out_red   = q[2];
  assign out_green = q[1];
  assign out_blue  = q[0];

endmodule

/* sv/rbb_checker.sv */
// ----------------------------------------------------------------------------
// rbb_checker
// Port-level checks of the blur core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rgb_box_blur_3x3_core_defines.svh"

module rbb_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic       frame_last
);

  logic [24:0] out_word;

  assign out_word = {out_red, out_green, out_blue, frame_last};

  // stalled result keeps its item
  `RBB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))

  // with the output register free or draining, every stage can move
  `RBB_ASSERT_NOW(a_ready_free, !out_valid || out_ready, in_ready)

  // reset empties the output
  `RBB_ASSERT_RST(a_reset_empty, rst, !out_valid)

endmodule

bind rgb_box_blur_3x3_core rbb_checker u_rbb_checker (.*);

/* sim/rgb_box_blur_3x3_core_test.sv */
// ----------------------------------------------------------------------------
// rgb_box_blur_3x3_core_test
// Self-checking bench for the streaming 3x3 RGB box blur. Pixels and drain
// items go in over valid/ready. An item-level predictor of the line stores,
// the window and the raster counters computes every blurred pixel. The
// checker compares each output item against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_box_blur_3x3_core_test;

  import rbb_pkg::*;

  localparam int ROW_CAP     = 1024;     // MAX_ROW_PIXELS of the instance
  localparam int CYCLE_LIMIT = 1000000;  // hard stop, far above a slow clean run
  localparam int SETTLE      = 10;       // cycles past the last result before a reg write
  localparam int ITEM_GOAL   = 650;      // items accepted over the whole run

  // one blurred output pixel as seen on the result port
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } blurred_px_t;

  // --------------------------------------------------------------------------
  // DUT signals, all inputs driven to known values from time zero
  // --------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_red    = '0;
  logic [7:0]            in_green  = '0;
  logic [7:0]            in_blue   = '0;
  logic                  drain     = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  logic [7:0]            out_red;
  logic [7:0]            out_green;
  logic [7:0]            out_blue;
  logic                  frame_last;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  rgb_box_blur_3x3_core #(
    .MAX_ROW_PIXELS(ROW_CAP)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_red     (in_red),
    .in_green   (in_green),
    .in_blue    (in_blue),
    .drain      (drain),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .frame_last (frame_last),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: its own copy of registers, line stores, window, counters
  // --------------------------------------------------------------------------
  logic [FW_W-1:0] cfg_width;
  logic [FH_W-1:0] cfg_height;
  rbb_px_t         older_line [ROW_CAP];
  rbb_px_t         newer_line [ROW_CAP];
  rbb_px_t         win [3][3];   // [above, center, below][left, mid, right]
  int              in_col, in_row, out_col, out_row;

  blurred_px_t     blurred_q[$];  // predicted pixels not yet seen on the output

  int idle_odds       = 0;   // 1-in-N chance of a gap / stall burst, 0 = none
  int mismatch_count  = 0;
  int items_accepted  = 0;
  int items_ignored   = 0;
  int blurred_checked = 0;
  int reg_writes      = 0;
  int cycle_count     = 0;

  // register values the core actually uses
  function automatic int active_width();
    if (cfg_width == 0) return 1;
    if (cfg_width > ROW_CAP) return ROW_CAP;
    return int'(cfg_width);
  endfunction

  function automatic int active_height();
    return (cfg_height == 0) ? 1 : int'(cfg_height);
  endfunction

  function automatic void restart_raster();
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  function automatic void clear_blur_state();
    cfg_width  = FW_RESET;
    cfg_height = FH_RESET;
    for (int i = 0; i < ROW_CAP; i++) begin
      older_line[i] = '0;
      newer_line[i] = '0;
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        win[r][c] = '0;
    restart_raster();
  endfunction

  // Rounded mean over the in-frame part of the window around column cc.
  // Neighbors off the top/bottom/left/right edge drop out of sum and count.
  function automatic blurred_px_t neighborhood_mean(int cc, int w, int h);
    int          sum_r, sum_g, sum_b, n, col;
    blurred_px_t res;
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    n     = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      if (dr < 0 && out_row == 0) continue;
      if (dr > 0 && out_row + 1 >= h) continue;
      for (int dc = -1; dc <= 1; dc++) begin
        col = cc + dc;
        if (dc < 0 && out_col == 0) continue;
        if (dc > 0 && out_col + 1 >= w) continue;
        if (col < 0 || col > 2) continue;
        sum_r += win[dr+1][col][2];
        sum_g += win[dr+1][col][1];
        sum_b += win[dr+1][col][0];
        n++;
      end
    end
    if (n == 0) n = 1;
    // half-up rounding
    res.red   = 8'((2 * sum_r + n) / (2 * n));
    res.green = 8'((2 * sum_g + n) / (2 * n));
    res.blue  = 8'((2 * sum_b + n) / (2 * n));
    res.last  = 1'b0;
    return res;
  endfunction

  // Advance the predictor by one accepted item; queue a pixel if one is due.
  function automatic void advance_blur(rbb_px_t px_in, logic is_drain);
    int          w, h, x;
    rbb_px_t     px, upper, mid;
    logic        emit;
    blurred_px_t res;
    w = active_width();
    h = active_height();
    // drains only count once the frame's pixels are all in; pixels only before
    if (is_drain) begin
      if (in_row < h) begin
        items_ignored++;
        return;
      end
      px = '0;
    end else begin
      if (in_row >= h) begin
        items_ignored++;
        return;
      end
      px = px_in;
    end

    x     = in_col % ROW_CAP;
    upper = older_line[x];
    mid   = newer_line[x];
    older_line[x] = mid;
    newer_line[x] = px;

    emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    res  = '0;

    // at column 0 the pending output is the previous row's last pixel,
    // whose window is the one before this shift
    if (emit && in_col == 0) res = neighborhood_mean(2, w, h);

    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = upper;
    win[1][2] = mid;
    win[2][2] = px;

    if (emit && in_col != 0) res = neighborhood_mean(1, w, h);

    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end

    if (!emit) return;

    res.last = (out_row + 1 >= h) && (out_col + 1 >= w);
    if (res.last) begin
      restart_raster();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    blurred_q.push_back(res);
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: register writes and accepted items feed the predictor, accepted
  // results are checked against the oldest prediction. Sampled at the edge,
  // inputs are driven by NBA so everything seen here is pre-edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    blurred_px_t want;
    if (rst) begin
      clear_blur_state();
    end else begin
      if (cfg_wr_en) begin
        case (rbb_reg_idx_t'(cfg_index))
          REG_FRAME_WIDTH:  cfg_width  = cfg_data[FW_W-1:0];
          REG_FRAME_HEIGHT: cfg_height = cfg_data[FH_W-1:0];
          default: ;
        endcase
        restart_raster();  // any write restarts the frame
      end
      if (in_valid && in_ready) begin
        items_accepted++;
        advance_blur({in_red, in_green, in_blue}, drain);
      end
      if (out_valid && out_ready) begin
        if (blurred_q.size() == 0) begin
          $error("output item with no prediction pending: r=%0d g=%0d b=%0d last=%0b",
                 out_red, out_green, out_blue, frame_last);
          mismatch_count++;
        end else begin
          want = blurred_q.pop_front();
          blurred_checked++;
          if (out_red !== want.red) begin
            $error("out_red: expected %0d, got %0d", want.red, out_red);
            mismatch_count++;
          end
          if (out_green !== want.green) begin
            $error("out_green: expected %0d, got %0d", want.green, out_green);
            mismatch_count++;
          end
          if (out_blue !== want.blue) begin
            $error("out_blue: expected %0d, got %0d", want.blue, out_blue);
            mismatch_count++;
          end
          if (frame_last !== want.last) begin
            $error("frame_last: expected %0b, got %0b", want.last, frame_last);
            mismatch_count++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side back-pressure: random stall bursts
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Offer one item, hold it until accepted. Optional gap burst first.
  task automatic push_item(input rbb_px_t px, input logic is_drain);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= px[2];
    in_green <= px[1];
    in_blue  <= px[0];
    drain    <= is_drain;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic rbb_px_t random_px();
    return {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
            8'($urandom_range(0, 255))};
  endfunction

  // Stop sending, let every prediction come out, then give items that
  // produce nothing time to leave the pipe.
  task automatic wait_for_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (blurred_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Only ever called with the core quiet.
  task automatic write_reg(input rbb_reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  // One frame of random pixels: stop_at < w*h abandons it (no drains),
  // pause_at >= 0 holds the sender there until all predictions are out,
  // noise_odds > 0 sprinkles stray drains among pixels and stray pixels
  // among drains (both ignored by the core).
  task automatic send_frame(input int w, input int h, input int stop_at,
                            input int pause_at, input int noise_odds,
                            input int extra_drains);
    for (int k = 0; k < w * h; k++) begin
      if (k == stop_at) return;
      if (k == pause_at) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (blurred_q.size() != 0) @(posedge clk);
      end
      if (noise_odds != 0 && $urandom_range(1, noise_odds) == 1)
        push_item(random_px(), 1'b1);
      push_item(random_px(), 1'b0);
    end
    for (int k = 0; k <= w; k++) begin
      if (noise_odds != 0 && $urandom_range(1, noise_odds) == 1)
        push_item(random_px(), 1'b0);
      push_item(random_px(), 1'b1);
    end
    repeat (extra_drains) push_item(random_px(), 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset geometry (640 x 480): a short run of pixels, well under one row,
  // so nothing may come out; the next register write abandons the frame.
  task automatic test_reset_geometry();
    idle_odds = 4;
    send_frame(int'(FW_RESET), int'(FH_RESET), 24, -1, 0, 0);
    wait_for_quiet();
  endtask

  // Hand-picked frames: half-way rounding, stray drains / pixels around the
  // frame end, zero width and height, full-scale and zero channel values.
  task automatic test_directed();
    rbb_px_t lo, hi;
    idle_odds = 4;
    lo = '0;
    hi = {8'd1, 8'd1, 8'd1};

    // 2x2: every output is a corner with sum 2 over 4 -> 0.5, rounds up to 1
    write_reg(REG_FRAME_WIDTH, 16'd2);
    write_reg(REG_FRAME_HEIGHT, 16'd2);
    push_item(lo, 1'b0);
    push_item(random_px(), 1'b1);          // drain before frame end: dropped
    push_item(hi, 1'b0);
    push_item(hi, 1'b0);
    push_item(lo, 1'b0);
    push_item({8'd7, 8'd7, 8'd7}, 1'b0);   // pixel after frame end: dropped
    repeat (3) push_item(random_px(), 1'b1);
    push_item(random_px(), 1'b1);          // drain after the last output: dropped
    wait_for_quiet();

    // zero width and height behave as a 1x1 frame
    write_reg(REG_FRAME_WIDTH, 16'd0);
    write_reg(REG_FRAME_HEIGHT, 16'd0);
    push_item({8'd255, 8'd255, 8'd255}, 1'b0);
    repeat (2) push_item(random_px(), 1'b1);
    wait_for_quiet();

    // 3x3 with extreme channels: red all 255 (sum 2295 at the center),
    // green all 0, blue alternating 0 / 255
    write_reg(REG_FRAME_WIDTH, 16'd3);
    write_reg(REG_FRAME_HEIGHT, 16'd3);
    for (int k = 0; k < 9; k++)
      push_item({8'd255, 8'd0, (k % 2) ? 8'd255 : 8'd0}, 1'b0);
    repeat (4) push_item(random_px(), 1'b1);
    wait_for_quiet();
  endtask

  // Widest rows, width above the line store size, upper data bits that the
  // width register drops, and the tallest height. Wide and tall frames are
  // cut short; the wide ones end before their first result is due.
  task automatic test_wide_and_tall();
    idle_odds = 6;
    write_reg(REG_FRAME_WIDTH, 16'd1024);
    write_reg(REG_FRAME_HEIGHT, 16'd2);
    send_frame(1024, 2, 40, -1, 0, 0);
    wait_for_quiet();

    write_reg(REG_FRAME_WIDTH, 16'd2047);    // clamps to the line store size
    write_reg(REG_FRAME_HEIGHT, 16'd1);
    send_frame(active_width(), 1, 40, -1, 0, 0);
    wait_for_quiet();

    write_reg(REG_FRAME_WIDTH, 16'hF803);    // only the low 11 bits count: 3
    write_reg(REG_FRAME_HEIGHT, 16'hFFFF);
    send_frame(active_width(), active_height(), 4 * active_width(), -1, 0, 0);
    wait_for_quiet();

    // short height again so frames that keep the geometry stay small
    write_reg(REG_FRAME_HEIGHT, 16'd4);
  endtask

  // Mostly well-formed small frames with random content; some abandoned,
  // some noisy, some reusing the previous geometry. Last stretch runs without gaps or stalls.
  task automatic test_random_frames();
    int goal, w, h, stop_at, pause_at, frame_no, noise_odds, extra;
    goal     = ITEM_GOAL;
    frame_no = 0;
    while (items_accepted < goal) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      h = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
      case ($urandom_range(0, 7))
        0: begin
          // same geometry, no write: frames run back to back
          w = active_width();
          h = active_height();
        end
        1: begin
          wait_for_quiet();
          write_reg(REG_FRAME_WIDTH, (w == 1 && $urandom_range(0, 1)) ? 16'd0 : 16'(w));
          h = active_height();
        end
        default: begin
          wait_for_quiet();
          write_reg(REG_FRAME_WIDTH, (w == 1 && $urandom_range(0, 1)) ? 16'd0 : 16'(w));
          write_reg(REG_FRAME_HEIGHT, (h == 1 && $urandom_range(0, 1)) ? 16'd0 : 16'(h));
        end
      endcase

      if (items_accepted > goal - 130) begin
        idle_odds = 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       idle_odds = 3;
          1:       idle_odds = 6;
          default: idle_odds = 40;
        endcase
      end

      // the frame that pauses the sender always runs to its end
      stop_at    = (frame_no != 2 && $urandom_range(0, 9) == 0) ?
                   $urandom_range(0, w * h - 1) : w * h;
      pause_at   = (frame_no == 2) ? (w * h) / 2 : -1;
      noise_odds = ($urandom_range(0, 3) == 0) ? 12 : 0;
      extra      = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      send_frame(w, h, stop_at, pause_at, noise_odds, extra);
      frame_no++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_geometry();
    test_directed();
    test_wide_and_tall();
    test_random_frames();

    idle_odds = 0;
    wait_for_quiet();

    $display("Run covered %0d items (%0d dropped by the core) and %0d blurred pixels,",
             items_accepted, items_ignored, blurred_checked);
    $display("with %0d register writes; small frames run whole, wide and tall ones cut short.",
             reg_writes);
    if (mismatch_count == 0 && blurred_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* rgb_box_blur_3x3_core.f */
+incdir+sv
sv/rbb_pkg.sv
sv/rbb_line_store.sv
sv/rbb_window_cell.sv
sv/rgb_box_blur_3x3_core.sv
sv/rbb_checker.sv
sim/rgb_box_blur_3x3_core_test.sv
